// ----- hdl/hcac_pkg.sv -----
// ----------------------------------------------------------------------------
// hcac_pkg
// Shared types and constants of the hashed cast answer cache.
// ----------------------------------------------------------------------------
package hcac_pkg;

	// number of slots; a power of two, the index is the low bits of the folded hash
	localparam int ENTRIES = 1024;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int WORD_W  = 64;
	localparam int HALF_W  = WORD_W / 2;

	localparam logic [HALF_W-1:0] MUL_VTABLE = 32'd2654435761;
	localparam logic [HALF_W-1:0] MUL_SOURCE = 32'd2246822519;
	localparam logic [HALF_W-1:0] MUL_DEST   = 32'd3266489917;
	localparam int                FOLD_SHIFT = 15;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		ST_NULL   = 3'd0,
		ST_HIT    = 3'd1,
		ST_MISS   = 3'd2,
		ST_BYPASS = 3'd3,
		ST_FILLED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CLS_NULL,
		CLS_BYPASS,
		CLS_CACHE
	} class_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_CMP
	} back_state_t;

	// classified item handed from the front to the back
	typedef struct packed {
		class_t                    cls;
		logic                      fill;
		logic [IDX_W-1:0]          idx;
		logic [WORD_W-1:0]         vtable;
		logic [WORD_W-1:0]         stype;
		logic [WORD_W-1:0]         dtype;
		logic signed [WORD_W-1:0]  hint;
		logic [WORD_W-1:0]         src;
		logic                      found;
		logic [WORD_W-1:0]         answer;
		logic [WORD_W-1:0]         disp;
	} entry_t;

	// one slot of the answer store
	typedef struct packed {
		logic                      valid;
		logic [WORD_W-1:0]         vtable;
		logic [WORD_W-1:0]         stype;
		logic [WORD_W-1:0]         dtype;
		logic signed [WORD_W-1:0]  hint;
		logic [WORD_W-1:0]         disp;
		logic                      found;
	} row_t;

endpackage

// ----- hdl/hcac_front.sv -----
// ----------------------------------------------------------------------------
// hcac_front
// Accepts items, classifies them and works out the slot index over two stages.
// ----------------------------------------------------------------------------
module hcac_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic [hcac_pkg::WORD_W-1:0]        object_vtable,
	input  logic [hcac_pkg::WORD_W-1:0]        source_type_id,
	input  logic [hcac_pkg::WORD_W-1:0]        dest_type_id,
	input  logic signed [hcac_pkg::WORD_W-1:0] cast_hint,
	input  logic [hcac_pkg::WORD_W-1:0]        source_address,
	input  logic                               cacheable,
	input  logic                               answer_found,
	input  logic [hcac_pkg::WORD_W-1:0]        answer_address,
	input  logic                               cache_enable,
	input  logic                               hold,
	output logic                               q_valid,
	input  logic                               q_ready,
	output hcac_pkg::entry_t                   q_data
);

	localparam int W = hcac_pkg::WORD_W;
	localparam int H = hcac_pkg::HALF_W;

	logic                  v_s1, v_s2;
	logic                  en1, en2;
	hcac_pkg::class_t      cls_s1;
	logic                  fill_s1;
	logic [W-1:0]          vt_s1, st_s1, dt_s1, src_s1, ans_s1;
	logic signed [W-1:0]   hint_s1;
	logic                  afound_s1;
	logic [W-1:0]          lo_vt_s1, lo_st_s1, lo_dt_s1;
	logic [H-1:0]          hi_vt_s1, hi_st_s1, hi_dt_s1;
	hcac_pkg::entry_t      ent_s2;

	logic [W-1:0]          lo_vt, lo_st, lo_dt;
	logic [H-1:0]          hi_vt, hi_st, hi_dt;
	hcac_pkg::class_t      cls_in;
	logic [W-1:0]          p_vt, p_st, p_dt, key, folded;
	logic                  f_ok;

	assign en2      = !v_s2 || q_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && !hold;
	assign q_valid  = v_s2;
	assign q_data   = ent_s2;

	// each 64 by 32 product split in two 32 by 32 halves, only low 64 bits kept
	always_comb begin
		lo_vt = W'(object_vtable[H-1:0]) * W'(hcac_pkg::MUL_VTABLE);
		lo_st = W'(source_type_id[H-1:0]) * W'(hcac_pkg::MUL_SOURCE);
		lo_dt = W'(dest_type_id[H-1:0]) * W'(hcac_pkg::MUL_DEST);
		hi_vt = object_vtable[W-1:H] * hcac_pkg::MUL_VTABLE;
		hi_st = source_type_id[W-1:H] * hcac_pkg::MUL_SOURCE;
		hi_dt = dest_type_id[W-1:H] * hcac_pkg::MUL_DEST;
		if (source_address == '0) begin
			cls_in = hcac_pkg::CLS_NULL;
		end else if (!cache_enable || !cacheable) begin
			cls_in = hcac_pkg::CLS_BYPASS;
		end else begin
			cls_in = hcac_pkg::CLS_CACHE;
		end
	end

	always_comb begin
		p_vt   = {lo_vt_s1[W-1:H] + hi_vt_s1, lo_vt_s1[H-1:0]};
		p_st   = {lo_st_s1[W-1:H] + hi_st_s1, lo_st_s1[H-1:0]};
		p_dt   = {lo_dt_s1[W-1:H] + hi_dt_s1, lo_dt_s1[H-1:0]};
		key    = p_vt ^ p_st ^ p_dt ^ hint_s1;
		folded = key ^ (key >> hcac_pkg::FOLD_SHIFT);
		// a found answer at address zero is kept as not found
		f_ok   = afound_s1 && (ans_s1 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid && in_ready;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cls_s1    <= cls_in;
			fill_s1   <= func;
			vt_s1     <= object_vtable;
			st_s1     <= source_type_id;
			dt_s1     <= dest_type_id;
			hint_s1   <= cast_hint;
			src_s1    <= source_address;
			afound_s1 <= answer_found;
			ans_s1    <= answer_address;
			lo_vt_s1  <= lo_vt;
			lo_st_s1  <= lo_st;
			lo_dt_s1  <= lo_dt;
			hi_vt_s1  <= hi_vt;
			hi_st_s1  <= hi_st;
			hi_dt_s1  <= hi_dt;
		end
		if (en2) begin
			ent_s2.cls    <= cls_s1;
			ent_s2.fill   <= fill_s1;
			ent_s2.idx    <= folded[hcac_pkg::IDX_W-1:0];
			ent_s2.vtable <= vt_s1;
			ent_s2.stype  <= st_s1;
			ent_s2.dtype  <= dt_s1;
			ent_s2.hint   <= hint_s1;
			ent_s2.src    <= src_s1;
			ent_s2.found  <= f_ok;
			ent_s2.answer <= ans_s1;
			ent_s2.disp   <= f_ok ? (ans_s1 - src_s1) : '0;
		end
	end

endmodule

// ----- hdl/hcac_fifo.sv -----
// ----------------------------------------------------------------------------
// hcac_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module hcac_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  hcac_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output hcac_pkg::entry_t pop_data
);

	localparam int PW = hcac_pkg::FIFO_PTR_W;

	hcac_pkg::entry_t  buf_q [hcac_pkg::FIFO_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != (PW+1)'(hcac_pkg::FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = buf_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(hcac_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(hcac_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/hcac_back.sv -----
// ----------------------------------------------------------------------------
// hcac_back
// Slot store, tag compare, fill write and the result register.
// ----------------------------------------------------------------------------
module hcac_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  hcac_pkg::entry_t            q_data,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  out_status,
	output logic                        out_found,
	output logic [hcac_pkg::WORD_W-1:0] out_addr
);

	localparam int IW = hcac_pkg::IDX_W;
	localparam int W  = hcac_pkg::WORD_W;

	hcac_pkg::row_t        mem [hcac_pkg::ENTRIES];
	hcac_pkg::back_state_t state_q, state_d;
	logic [IW-1:0]         clr_idx_q;
	hcac_pkg::entry_t      cur_q;
	hcac_pkg::row_t        rd_q;
	logic                  out_v_q;
	hcac_pkg::status_t     status_q, status_d;
	logic                  found_q, found_d;
	logic [W-1:0]          addr_q, addr_d;

	logic                  out_free, load_out, mem_we, match, hit_found;
	logic [IW-1:0]         wr_idx;
	hcac_pkg::row_t        wr_row;
	logic [W-1:0]          sum;

	assign out_free   = !out_v_q || out_ready;
	assign clearing   = state_q == hcac_pkg::BK_CLEAR;
	assign out_valid  = out_v_q;
	assign out_status = status_q;
	assign out_found  = found_q;
	assign out_addr   = addr_q;

	assign match = rd_q.valid && (rd_q.vtable == cur_q.vtable) && (rd_q.stype == cur_q.stype)
		&& (rd_q.dtype == cur_q.dtype) && (rd_q.hint == cur_q.hint);
	assign sum       = cur_q.src + rd_q.disp;
	assign hit_found = rd_q.found && (sum != '0);

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		status_d = hcac_pkg::ST_MISS;
		found_d  = 1'b0;
		addr_d   = '0;
		mem_we   = 1'b0;
		wr_idx   = cur_q.idx;
		wr_row   = '0;
		case (state_q)
			hcac_pkg::BK_CLEAR: begin
				mem_we = 1'b1;
				wr_idx = clr_idx_q;
				if (clr_idx_q == IW'(hcac_pkg::ENTRIES - 1)) begin
					state_d = hcac_pkg::BK_IDLE;
				end
			end
			hcac_pkg::BK_IDLE: begin
				if (q_valid) begin
					if (q_data.cls == hcac_pkg::CLS_CACHE) begin
						q_pop   = 1'b1;
						state_d = hcac_pkg::BK_CMP;
					end else if (out_free) begin
						q_pop    = 1'b1;
						load_out = 1'b1;
						status_d = (q_data.cls == hcac_pkg::CLS_NULL) ? hcac_pkg::ST_NULL
							: hcac_pkg::ST_BYPASS;
					end
				end
			end
			hcac_pkg::BK_CMP: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = hcac_pkg::BK_IDLE;
					if (cur_q.fill) begin
						mem_we        = 1'b1;
						wr_row.valid  = 1'b1;
						wr_row.vtable = cur_q.vtable;
						wr_row.stype  = cur_q.stype;
						wr_row.dtype  = cur_q.dtype;
						wr_row.hint   = cur_q.hint;
						wr_row.disp   = cur_q.disp;
						wr_row.found  = cur_q.found;
						status_d      = hcac_pkg::ST_FILLED;
						found_d       = cur_q.found;
						addr_d        = cur_q.found ? cur_q.answer : '0;
					end else if (match) begin
						status_d = hcac_pkg::ST_HIT;
						found_d  = hit_found;
						addr_d   = hit_found ? sum : '0;
					end
				end
			end
			default: begin
				state_d = hcac_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hcac_pkg::BK_CLEAR;
			clr_idx_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (load_out) begin
			status_q <= status_d;
			found_q  <= found_d;
			addr_q   <= addr_d;
		end
	end

	// slot store: one write port, registered read on the pop transaction
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_q <= mem[q_data.idx];
		end
	end

endmodule

// ----- hdl/hashed_cast_answer_cache.sv -----
// ----------------------------------------------------------------------------
// hashed_cast_answer_cache
// Direct-mapped answer cache for type-cast lookups and fills.
// ----------------------------------------------------------------------------
// path: a cached lookup or fill goes from the input transaction to the result
//   transaction through two hash stages, the queue, the slot read in the back
//   and the result register; null and bypass items skip the slot read
// back: a cached lookup or fill is a slot read, then compare and write, and no
//   new item is taken until it is done; null and bypass items go straight to the result register
// reset: the slot store is cleared one slot a cycle, all 1024 slots, while no
//   input is accepted; cache_enable resets to 1
module hashed_cast_answer_cache (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// object_vtable, source_type_id, dest_type_id, cast_hint, source_address,
	// answer_found, answer_address, zero pad
	input  logic [391:0] s_axis_tdata,
	// func, cacheable
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found, result_address, zero pad
	output logic [71:0]  m_axis_tdata,
	// status
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data
);

	logic             enable_q;
	logic             hold;
	logic             fq_valid, fq_ready, bq_valid, bq_pop;
	hcac_pkg::entry_t fq_data, bq_data;
	logic             res_found;
	logic [63:0]      res_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	hcac_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.func           (s_axis_tuser[0]),
		.object_vtable  (s_axis_tdata[63:0]),
		.source_type_id (s_axis_tdata[127:64]),
		.dest_type_id   (s_axis_tdata[191:128]),
		.cast_hint      (s_axis_tdata[255:192]),
		.source_address (s_axis_tdata[319:256]),
		.cacheable      (s_axis_tuser[1]),
		.answer_found   (s_axis_tdata[320]),
		.answer_address (s_axis_tdata[384:321]),
		.cache_enable   (enable_q),
		.hold           (hold),
		.q_valid        (fq_valid),
		.q_ready        (fq_ready),
		.q_data         (fq_data)
	);

	hcac_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_pop),
		.pop_data   (bq_data)
	);

	hcac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (bq_valid),
		.q_pop      (bq_pop),
		.q_data     (bq_data),
		.clearing   (hold),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_found  (res_found),
		.out_addr   (res_addr)
	);

	assign m_axis_tdata = {7'd0, res_addr, res_found};

endmodule
